FILE: sv/sscsd_pkg.sv
package sscsd_pkg;

  // opcodes of an input word
  localparam logic [1:0] OP_SET_TIME = 2'd0;
  localparam logic [1:0] OP_CLEAR    = 2'd1;
  localparam logic [1:0] OP_SCAN     = 2'd2;

  // decimal point bit of a segment byte
  localparam logic [7:0] DP_BIT = 8'h80;

  // digits on the display and bits shifted per scan tick
  localparam int NUM_DIGITS = 4;
  localparam int SCAN_BITS  = 16;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef logic [SCAN_BITS-1:0] scan_word_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic       dot_on;
  } in_item_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_after;
  } out_item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // active-high segment code of one decimal digit
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

FILE: sv/sscsd_front.sv
module sscsd_front
  import sscsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_item,
  input  q_stat_t    q_stat,
  output logic       q_push,
  output scan_word_t q_word
);

  logic [7:0] seg_r [NUM_DIGITS];
  logic [1:0] scan_pos_r;
  logic       acc;

  // hour reduction: quotient estimate h*85>>11 is floor or one below
  logic [14:0] h_prod;
  logic [3:0]  h_q;
  logic [5:0]  h_raw;
  logic [4:0]  h_mod;
  logic [1:0]  h_tens;
  logic [3:0]  h_ones;

  // minute reduction: quotient estimate m*17>>10 is floor or one below
  logic [12:0] m_prod;
  logic [2:0]  m_q;
  logic [6:0]  m_raw;
  logic [5:0]  m_mod;
  logic [2:0]  m_tens;
  logic [3:0]  m_ones;

  logic [7:0] sel_byte;

  assign in_full = q_stat.full;
  assign acc     = in_push && !in_full;

  // modulo and digit split
  always_comb begin
    h_prod = 15'(in_item.hours) * 15'd85;
    h_q    = h_prod[14:11];
    h_raw  = 6'(9'(in_item.hours) - 9'(h_q) * 9'd24);
    h_mod  = (h_raw >= 6'd24) ? 5'(h_raw - 6'd24) : h_raw[4:0];
    if (h_mod >= 5'd20) begin
      h_tens = 2'd2;
    end else if (h_mod >= 5'd10) begin
      h_tens = 2'd1;
    end else begin
      h_tens = 2'd0;
    end
    h_ones = 4'(h_mod - 5'(h_tens) * 5'd10);

    m_prod = 13'(in_item.minutes) * 13'd17;
    m_q    = m_prod[12:10];
    m_raw  = 7'(9'(in_item.minutes) - 9'(m_q) * 9'd60);
    m_mod  = (m_raw >= 7'd60) ? 6'(m_raw - 7'd60) : m_raw[5:0];
    m_tens = 3'd0;
    for (int i = 1; i <= 5; i++) begin
      if (m_mod >= 6'(i * 10)) begin
        m_tens = 3'(i);
      end
    end
    m_ones = 4'(m_mod - 6'(m_tens) * 6'd10);
  end

  // segment buffer and scan position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        seg_r[i] <= 8'h00;
      end
      scan_pos_r <= 2'd0;
    end else if (acc) begin
      case (in_item.opcode)
        OP_SET_TIME: begin
          seg_r[0] <= seg_code(4'(h_tens));
          seg_r[1] <= in_item.dot_on ? (seg_code(h_ones) | DP_BIT)
                                     : (seg_code(h_ones) & ~DP_BIT);
          seg_r[2] <= seg_code(4'(m_tens));
          seg_r[3] <= seg_code(m_ones);
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            seg_r[i] <= 8'h00;
          end
        end
        OP_SCAN: begin
          scan_pos_r <= scan_pos_r + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // scan word for the back: active-low select byte, then segment byte
  always_comb begin
    sel_byte = ~(8'd1 << scan_pos_r);
    q_word   = {sel_byte, seg_r[scan_pos_r]};
    q_push   = acc && (in_item.opcode == OP_SCAN);
  end

`ifndef SYNTHESIS
  a_scan_advance: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> scan_pos_r == 2'($past(scan_pos_r) + 2'd1))
    else $error("scan position did not advance after a scan tick");
  a_hold_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !q_push |=> $stable(scan_pos_r))
    else $error("scan position moved without a scan tick");
`endif

endmodule

FILE: sv/sscsd_queue.sv
module sscsd_queue
  import sscsd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  scan_word_t push_word,
  input  logic       pop,
  output scan_word_t head_word,
  output q_stat_t    stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scan_word_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_word  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("pop from an empty queue");
`endif

endmodule

FILE: sv/sscsd_back.sv
module sscsd_back
  import sscsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  scan_word_t q_word,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_item
);

  localparam int BW = $clog2(SCAN_BITS);

  scan_word_t    word_r;
  logic [BW-1:0] cnt_r;
  logic          busy_r;
  logic          fire;
  logic          last;
  logic          load;

  assign out_empty            = !busy_r;
  assign fire                 = out_pop && busy_r;
  assign last                 = (cnt_r == BW'(SCAN_BITS - 1));
  assign load                 = (!busy_r || (fire && last)) && !q_stat.empty;
  assign q_pop                = load;
  assign out_item.serial_bit  = word_r[SCAN_BITS-1];
  assign out_item.latch_after = last;

  // bit count and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (fire) begin
      if (last) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + BW'(1);
    end
  end

  // shift register, msb first
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= q_word;
    end else if (fire) begin
      word_r <= {word_r[SCAN_BITS-2:0], 1'b0};
    end
  end

`ifndef SYNTHESIS
  a_fresh_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> cnt_r == '0)
    else $error("bit count not restarted after the latch bit");
  a_idle_load: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !q_stat.empty |=> busy_r)
    else $error("waiting scan word not taken by idle shifter");
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == '0)
    else $error("idle shifter holds a partial count");
`endif

endmodule

FILE: sv/seven_segment_clock_scan_driver.sv
// four-digit seven-segment clock driver for two chained shift registers
// input channel: push a word when full is low; opcode set time loads
//   hours mod 24 and minutes mod 60 as four digits (dot after hour
//   ones if dot_on), clear blanks the display, scan tick emits sixteen
//   serial bits, and the unused opcode is dropped
// result channel: while empty is low, out_item holds the next serial bit,
//   msb first (active-low digit select byte, then segment byte);
//   latch_after marks the sixteenth bit; pop takes it
// order: with the shifter idle, a scan tick's word is written into the
//   scan queue, then loaded into the shifter, which shows its first bit;
//   set time and clear update the buffer at the accepting edge, so a
//   scan tick pushed in the next cycle already shows them
// throughput: one word accepted per cycle while the scan queue has room;
//   the shifter sends a scan tick one bit per cycle while pop stays high,
//   and loads the next queued word as the sixteenth bit is popped
// stall: a held-off pop freezes the current bit; later scan ticks fill
//   the scan queue and full then holds off every word, set and clear too
// reset: segment buffer blank, scan position at digit zero, queue and
//   shifter empty
module seven_segment_clock_scan_driver
  import sscsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  q_stat_t    q_stat;
  logic       q_push;
  logic       q_pop;
  scan_word_t q_word_in;
  scan_word_t q_word_out;

  // front: decode and buffer update
  sscsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_word  (q_word_in)
  );

  // scan word queue
  sscsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_word_in),
    .pop       (q_pop),
    .head_word (q_word_out),
    .stat      (q_stat)
  );

  // back: serial shifter
  sscsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_word    (q_word_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
